// File: rtl/core/hotp_pkg.sv
`default_nettype none
package hotp_pkg;

    localparam int KeyWords = 8;
    localparam int Rounds = 80;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_TRUNC,
        ST_MOD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic fold;
        logic init;
    } sha_ctl_t;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        if (r < 7'd20)
            k = 32'h5A827999;
        else if (r < 7'd40)
            k = 32'h6ED9EBA1;
        else if (r < 7'd60)
            k = 32'h8F1BBCDC;
        else
            k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (r < 7'd20)
            f = (b & c) | (~b & d);
        else if (r < 7'd40 || r >= 7'd60)
            f = b ^ c ^ d;
        else
            f = (b & c) | (b & d) | (c & d);
        return f;
    endfunction

    function automatic logic [33:0] pow10(input logic [3:0] dg);
        logic [33:0] m;
        unique case (dg)
            4'd0: m = 34'd1;
            4'd1: m = 34'd10;
            4'd2: m = 34'd100;
            4'd3: m = 34'd1000;
            4'd4: m = 34'd10000;
            4'd5: m = 34'd100000;
            4'd6: m = 34'd1000000;
            4'd7: m = 34'd10000000;
            4'd8: m = 34'd100000000;
            default: m = 34'd1000000000;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/hotp_sha_round.sv
`default_nettype none
module hotp_sha_round (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hotp_pkg::sha_ctl_t  ctl,
    input  wire logic [511:0]        block,
    input  wire logic [6:0]          round,
    output logic [159:0]             hash
);

    logic [511:0] w_reg;
    logic [511:0] w_next;
    logic [159:0] h_reg;
    logic [159:0] h_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [31:0]  wt;
    logic [31:0]  wx;
    logic [31:0]  wn;
    logic [31:0]  t;

    assign wt = w_reg[511:480];
    assign wx = w_reg[64+:32] ^ w_reg[224+:32] ^ w_reg[416+:32] ^ wt;
    assign wn = {wx[30:0], wx[31]};
    assign t = {a_reg[26:0], a_reg[31:27]}
             + hotp_pkg::round_f(round, b_reg, c_reg, d_reg)
             + e_reg + hotp_pkg::round_k(round) + wt;

    always_comb
    begin
        w_next = w_reg;
        h_next = h_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg; e_next = e_reg;
        if (ctl.init)
            h_next = {hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2, hotp_pkg::H3,
                      hotp_pkg::H4};
        if (ctl.load)
        begin
            w_next = block;
            {a_next, b_next, c_next, d_next, e_next} = ctl.init ?
                {hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2, hotp_pkg::H3, hotp_pkg::H4}
                : h_reg;
        end
        else if (ctl.step)
        begin
            w_next = {w_reg[479:0], wn};
            a_next = t;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end
        else if (ctl.fold)
        begin
            h_next = {h_reg[159:128] + a_reg, h_reg[127:96] + b_reg,
                      h_reg[95:64] + c_reg, h_reg[63:32] + d_reg, h_reg[31:0] + e_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= '0;
        end
        else
        begin
            h_reg <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
        e_reg <= e_next;
    end

    assign hash = h_reg;

endmodule
`default_nettype wire

// File: rtl/core/hotp_one_time_code.sv
// sequence from input accept to out_valid: four sha-1 blocks, each a load,
// 80 rounds and a fold, then a truncation state, 31 restoring-subtract
// steps of the modulo and an output state
// items: a new item is accepted only once the last one is done, since the
// sha-1 round unit is shared; a stalled result holds the sequencer in its last state
// reset: asynchronous active low, clears key registers and the sequencer
`default_nettype none
module hotp_one_time_code (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] counter,
    input  wire logic [3:0]  digits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [29:0]      code
);

    hotp_pkg::state_t state_reg, state_next;
    logic [63:0]  key_reg [hotp_pkg::KeyWords];
    logic [63:0]  ctr_reg;
    logic [3:0]   dig_reg;
    logic [1:0]   blk_reg, blk_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic [159:0] inner_reg;
    logic [30:0]  rem_reg, rem_next;
    logic [60:0]  div_reg, div_next;
    logic [4:0]   sh_reg, sh_next;
    logic [29:0]  code_reg;
    logic         cap_inner, cap_code;
    logic [511:0] keyblk, block;
    logic [7:0]   pad;
    logic [159:0] hash;
    logic [159:0] hrot;
    logic [30:0]  tv;
    hotp_pkg::sha_ctl_t ctl;

    assign keyblk = {key_reg[0], key_reg[1], key_reg[2], key_reg[3],
                     key_reg[4], key_reg[5], key_reg[6], key_reg[7]};
    assign pad = blk_reg[1] ? 8'h5C : 8'h36;

    always_comb
    begin
        unique case (blk_reg) inside
            2'd0, 2'd2: block = keyblk ^ {64{pad}};
            2'd1: block = {ctr_reg, 8'h80, 376'd0, 64'd576};
            default: block = {inner_reg, 8'h80, 280'd0, 64'd672};
        endcase
    end

    hotp_sha_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .block (block),
        .round (rnd_reg),
        .hash  (hash)
    );

    assign hrot = hash << {hash[3:0], 3'd0};
    assign tv = hrot[158:128];

    always_comb
    begin
        state_next = state_reg;
        blk_next = blk_reg;
        rnd_next = rnd_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        sh_next = sh_reg;
        ctl = '0;
        cap_inner = 1'b0;
        cap_code = 1'b0;
        unique case (state_reg)
            hotp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    blk_next = 2'd0;
                    state_next = hotp_pkg::ST_LOAD;
                end
            end
            hotp_pkg::ST_LOAD:
            begin
                ctl.load = 1'b1;
                ctl.init = (blk_reg == 2'd0) || (blk_reg == 2'd2);
                if (blk_reg == 2'd2)
                    cap_inner = 1'b1;
                rnd_next = '0;
                state_next = hotp_pkg::ST_ROUND;
            end
            hotp_pkg::ST_ROUND:
            begin
                ctl.step = 1'b1;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'(hotp_pkg::Rounds - 1))
                    state_next = hotp_pkg::ST_FOLD;
            end
            hotp_pkg::ST_FOLD:
            begin
                ctl.fold = 1'b1;
                blk_next = blk_reg + 2'd1;
                state_next = (blk_reg == 2'd3) ? hotp_pkg::ST_TRUNC : hotp_pkg::ST_LOAD;
            end
            hotp_pkg::ST_TRUNC:
            begin
                rem_next = tv;
                div_next = {27'd0, hotp_pkg::pow10(dig_reg)} << 5'd30;
                sh_next = 5'd30;
                state_next = hotp_pkg::ST_MOD;
            end
            hotp_pkg::ST_MOD:
            begin
                if ({30'd0, rem_reg} >= div_reg)
                    rem_next = rem_reg - div_reg[30:0];
                div_next = div_reg >> 1;
                sh_next = sh_reg - 5'd1;
                if (sh_reg == 5'd0)
                    state_next = hotp_pkg::ST_DONE;
            end
            hotp_pkg::ST_DONE:
            begin
                cap_code = 1'b1;
                if (!out_valid || !out_stall)
                    state_next = hotp_pkg::ST_IDLE;
            end
            default: state_next = hotp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hotp_pkg::ST_IDLE;
            out_valid <= 1'b0;
            blk_reg <= '0;
            rnd_reg <= '0;
            sh_reg <= '0;
            for (int i = 0; i < hotp_pkg::KeyWords; i++)
                key_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            blk_reg <= blk_next;
            rnd_reg <= rnd_next;
            sh_reg <= sh_next;
            if (cfg_valid && cfg_ready)
                key_reg[cfg_index] <= cfg_data;
            if (cap_code && (!out_valid || !out_stall))
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == hotp_pkg::ST_IDLE && in_valid)
        begin
            ctr_reg <= counter;
            dig_reg <= (digits > 4'd9) ? 4'd9 : digits;
        end
        if (cap_inner)
            inner_reg <= hash;
        rem_reg <= rem_next;
        div_reg <= div_next;
        if (cap_code && (!out_valid || !out_stall))
            code_reg <= rem_reg[29:0];
    end

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != hotp_pkg::ST_IDLE);
    assign code = code_reg;

    ap_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg <= 7'(hotp_pkg::Rounds))
        else $error("round counter out of range");
    ap_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == hotp_pkg::ST_LOAD)
        else $error("accepted item did not start");
    ap_mod_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hotp_pkg::ST_DONE) |-> ({3'd0, rem_reg} < hotp_pkg::pow10(dig_reg)))
        else $error("remainder not reduced");

endmodule
`default_nettype wire
